// ----- rtl/ofd_pkg.sv -----
package ofd_pkg;

	// message type bytes
	localparam logic [7:0] TYPE_ENTER  = 8'h4F;
	localparam logic [7:0] TYPE_CANCEL = 8'h58;

	// frame lengths and byte counter saturation
	localparam logic [5:0] ENTER_LEN  = 6'd47;
	localparam logic [5:0] CANCEL_LEN = 6'd11;
	localparam logic [5:0] COUNT_SAT  = 6'd48;

	// byte positions of the fields inside a frame
	localparam logic [5:0] REF_FIRST       = 6'd1;
	localparam logic [5:0] REF_LAST        = 6'd4;
	localparam logic [5:0] ENTER_SIDE_POS  = 6'd5;
	localparam logic [5:0] ENTER_QTY_POS   = 6'd6;
	localparam logic [5:0] ENTER_SYM_POS   = 6'd10;
	localparam logic [5:0] ENTER_PRICE_POS = 6'd18;
	localparam logic [5:0] CANCEL_QTY_POS  = 6'd5;
	localparam logic [5:0] QTY_BYTES       = 6'd4;
	localparam logic [5:0] FIELD_BYTES     = 6'd8;

	typedef enum logic [1:0] {
		ST_ENTER  = 2'd0,
		ST_CANCEL = 2'd1,
		ST_REJECT = 2'd2
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] user_ref;
		logic [7:0]  side_code;
		logic [31:0] quantity;
		logic [63:0] symbol_raw;
		logic [63:0] price_fixed;
	} ofd_result_t;

endpackage

// ----- rtl/ofd_capture.sv -----
module ofd_capture (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output ofd_pkg::ofd_result_t result
);
	import ofd_pkg::*;

	logic [5:0]  byte_count_q;
	logic [7:0]  frame_type_q;
	logic [31:0] ref_q;
	logic [7:0]  side_q;
	logic [31:0] qty_q;
	logic [63:0] symbol_q;
	logic [63:0] price_q;

	logic [5:0]  count;
	logic [7:0]  type_n;
	logic [31:0] ref_n;
	logic [7:0]  side_n;
	logic [31:0] qty_n;
	logic [63:0] symbol_n;
	logic [63:0] price_n;
	logic        is_enter;
	logic        is_cancel;

	// saturating byte count including the current byte
	assign count = (byte_count_q < COUNT_SAT) ? byte_count_q + 6'd1 : COUNT_SAT;

	// field shift registers, next values for the current byte
	always_comb begin
		type_n   = frame_type_q;
		ref_n    = ref_q;
		side_n   = side_q;
		qty_n    = qty_q;
		symbol_n = symbol_q;
		price_n  = price_q;
		if (byte_count_q == 6'd0) begin
			type_n   = data_byte;
			ref_n    = '0;
			side_n   = '0;
			qty_n    = '0;
			symbol_n = '0;
			price_n  = '0;
		end else if (byte_count_q >= REF_FIRST && byte_count_q <= REF_LAST) begin
			ref_n = {ref_q[23:0], data_byte};
		end else if (frame_type_q == TYPE_ENTER) begin
			if (byte_count_q == ENTER_SIDE_POS) begin
				side_n = data_byte;
			end else if (byte_count_q >= ENTER_QTY_POS &&
					byte_count_q < ENTER_QTY_POS + QTY_BYTES) begin
				qty_n = {qty_q[23:0], data_byte};
			end else if (byte_count_q >= ENTER_SYM_POS &&
					byte_count_q < ENTER_SYM_POS + FIELD_BYTES) begin
				symbol_n = {symbol_q[55:0], data_byte};
			end else if (byte_count_q >= ENTER_PRICE_POS &&
					byte_count_q < ENTER_PRICE_POS + FIELD_BYTES) begin
				price_n = {price_q[55:0], data_byte};
			end
		end else if (frame_type_q == TYPE_CANCEL) begin
			if (byte_count_q >= CANCEL_QTY_POS &&
					byte_count_q < CANCEL_QTY_POS + QTY_BYTES) begin
				qty_n = {qty_q[23:0], data_byte};
			end
		end
	end

	// frame check and result fields
	assign is_enter  = (type_n == TYPE_ENTER) && (count == ENTER_LEN);
	assign is_cancel = (type_n == TYPE_CANCEL) && (count == CANCEL_LEN);

	always_comb begin
		result = '0;
		if (is_enter) begin
			result.status      = ST_ENTER;
			result.user_ref    = ref_n;
			result.side_code   = side_n;
			result.quantity    = qty_n;
			result.symbol_raw  = symbol_n;
			result.price_fixed = price_n;
		end else if (is_cancel) begin
			result.status   = ST_CANCEL;
			result.user_ref = ref_n;
			result.quantity = qty_n;
		end else begin
			result.status = ST_REJECT;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			frame_type_q <= '0;
			ref_q        <= '0;
			side_q       <= '0;
			qty_q        <= '0;
			symbol_q     <= '0;
			price_q      <= '0;
		end else if (step_en) begin
			byte_count_q <= last_byte ? 6'd0 : count;
			frame_type_q <= type_n;
			ref_q        <= ref_n;
			side_q       <= side_n;
			qty_q        <= qty_n;
			symbol_q     <= symbol_n;
			price_q      <= price_n;
		end
	end

endmodule

// ----- rtl/ouch_frame_decoder_top.sv -----
// channel  direction  handshake          payload
// in       receive    in_valid/in_stall  data_byte, last_byte
// out      send       out_valid/out_stall status, user_ref, side_code, quantity,
//                                        symbol_raw, price_fixed
//
// one byte per cycle sustained; a byte goes through the input register and
// the field update, and a frame's result enters the output register as its
// last byte leaves the input register. reset clears the byte counter, frame
// type and fields so the first byte starts a frame. a stalled result holds in
// the output register; only a last byte waits behind it, others keep flowing.
module ouch_frame_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] user_ref,
	output logic [7:0]  side_code,
	output logic [31:0] quantity,
	output logic [63:0] symbol_raw,
	output logic [63:0] price_fixed
);
	import ofd_pkg::*;

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        advance;
	logic        in_xfer;
	ofd_result_t result;
	ofd_result_t res_q;
	logic        out_valid_q;

	// a byte in the input register moves on unless it ends a frame and the
	// previous result is still stalled
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	ofd_capture u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.result    (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_q <= result;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = res_q.status;
	assign user_ref    = res_q.user_ref;
	assign side_code   = res_q.side_code;
	assign quantity    = res_q.quantity;
	assign symbol_raw  = res_q.symbol_raw;
	assign price_fixed = res_q.price_fixed;

endmodule
